// ===== design/irw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irw_pkg
// Constants and types for the byte-wide indirect register window.
// ----------------------------------------------------------------------------
package irw_pkg;

  localparam int VRAM_ADDR_BITS = 25;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 72;

  localparam logic [31:0] REG_SPACE_LIMIT  = 32'h0100_0000;
  localparam logic [23:0] FB_CONFIG_ADDR   = 24'h10_0200;
  localparam logic [23:0] RAMDAC_CTRL_ADDR = 24'h68_0600;
  localparam logic [23:0] SIZE_REG_ADDR    = 24'h10_0000;
  localparam logic [23:0] BUS_ID0_ADDR     = 24'h00_0000;
  localparam logic [23:0] BUS_ID1_ADDR     = 24'h00_0001;
  localparam logic [23:0] BUS_ID2_ADDR     = 24'h00_0002;
  localparam logic [31:0] VRAM_BASE_MASK   = 32'h0040_0000;

  localparam logic [7:0] BUS_ID0_BYTE = 8'h11;
  localparam logic [7:0] BUS_ID1_BYTE = 8'h01;
  localparam logic [7:0] BUS_ID2_BYTE = 8'h03;
  localparam logic [7:0] SIZE_BASE_BYTE = 8'h14;

  localparam logic [7:0] ID_BYTES [4] = '{8'h65, 8'hd0, 8'h16, 8'h2b};

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
  } irw_req_t;

  typedef struct packed {
    logic [7:0]                read_data;
    logic                      vram_write;
    logic [VRAM_ADDR_BITS-1:0] vram_addr;
    logic [31:0]               vram_data;
  } irw_rsp_t;

endpackage

// ===== design/indirect_register_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_register_window
// Byte-wide indirect access window onto an address/data pair, two control
// registers and video memory word writes.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata/tuser, low bit first)
// s        in   tdata: reg_offset[4:0], write_data[12:5]; tuser: req_type
// m        out  tdata: read_data, vram_addr, vram_data; tuser: vram_write
// cfg      in   cfg_data: mem_size_sel
//
// One beat in, one beat out; a new beat is taken every cycle unless the result stalls.
// A beat passes the input register, then the decode and state update
// into the result register.
// rst is synchronous and clears valid flags and the window state.
// A stalled result holds the input register; s_tready drops only while both
// stages are full and m_tready is low.
// ----------------------------------------------------------------------------
module indirect_register_window
  import irw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // reg_offset[4:0], write_data[12:5]
  input  logic [0:0]           s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // read_data[7:0], vram_addr[32:8],
                                          // vram_data[64:33], zero[71:65]
  output logic [0:0]           m_tuser,   // vram_write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data   // mem_size_sel
);

  logic [1:0]  mem_size_sel;
  logic [31:0] window_address;
  logic [31:0] window_data;
  logic [31:0] fb_config;
  logic [31:0] ramdac_ctrl;

  logic        in_valid;
  irw_req_t    in_req;
  logic        out_valid;
  irw_rsp_t    out_rsp;

  logic        advance;
  irw_rsp_t    rsp_next;
  logic [31:0] window_address_next;
  logic [31:0] window_data_next;
  logic [31:0] fb_config_next;
  logic [31:0] ramdac_ctrl_next;

  logic [1:0]  lane;
  logic [4:0]  shamt;
  logic [31:0] byte_mask;
  logic [31:0] byte_val;
  logic [23:0] rd_addr;
  logic [31:0] rd_sum;
  logic [7:0]  rd_byte;
  logic [31:0] vram_mask;
  logic [31:0] vram_off;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;

  always_comb begin
    lane      = in_req.reg_offset[1:0];
    shamt     = {lane, 3'b000};
    byte_mask = 32'h0000_00ff << shamt;
    byte_val  = {24'h0, in_req.write_data} << shamt;
    rd_sum    = window_address + {30'h0, lane};
    rd_addr   = rd_sum[23:0];
    vram_mask = (VRAM_BASE_MASK << mem_size_sel) - 32'h1;
    vram_off  = window_address - REG_SPACE_LIMIT;

    if (rd_addr == BUS_ID0_ADDR) begin
      rd_byte = BUS_ID0_BYTE;
    end else if (rd_addr == BUS_ID1_ADDR) begin
      rd_byte = BUS_ID1_BYTE;
    end else if (rd_addr == BUS_ID2_ADDR) begin
      rd_byte = BUS_ID2_BYTE;
    end else if (rd_addr == SIZE_REG_ADDR) begin
      rd_byte = SIZE_BASE_BYTE | {6'h0, mem_size_sel + 2'd1};
    end else if (rd_addr[23:2] == FB_CONFIG_ADDR[23:2]) begin
      rd_byte = fb_config[{rd_addr[1:0], 3'b000} +: 8];
    end else if (rd_addr[23:2] == RAMDAC_CTRL_ADDR[23:2]) begin
      rd_byte = ramdac_ctrl[{rd_addr[1:0], 3'b000} +: 8];
    end else begin
      rd_byte = 8'h00;
    end

    rsp_next            = '0;
    window_address_next = window_address;
    window_data_next    = window_data;
    fb_config_next      = fb_config;
    ramdac_ctrl_next    = ramdac_ctrl;

    if (in_req.req_type == REQ_READ) begin
      if (in_req.reg_offset[4:2] == 3'd0) begin
        rsp_next.read_data = ID_BYTES[lane];
      end else if (in_req.reg_offset[4:2] == 3'd2) begin
        rsp_next.read_data = rd_byte;
      end
    end else begin
      if (in_req.reg_offset[4:2] == 3'd1) begin
        window_address_next = (window_address & ~byte_mask) | byte_val;
      end else if (in_req.reg_offset[4:3] == 2'd1 || in_req.reg_offset[4:3] == 2'd2) begin
        window_data_next = (window_data & ~byte_mask) | byte_val;
        if (lane == 2'd3) begin
          if (window_address < REG_SPACE_LIMIT) begin
            if (window_address[23:0] == FB_CONFIG_ADDR) begin
              fb_config_next = window_data_next;
            end else if (window_address[23:0] == RAMDAC_CTRL_ADDR) begin
              ramdac_ctrl_next = window_data_next;
            end
          end else begin
            rsp_next.vram_write = 1'b1;
            rsp_next.vram_addr  = vram_off[VRAM_ADDR_BITS-1:0] & vram_mask[VRAM_ADDR_BITS-1:0];
            rsp_next.vram_data  = window_data_next;
          end
        end
      end
      if (in_req.reg_offset[4]) begin
        window_address_next = window_address_next + 32'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size_sel   <= 2'd0;
      window_address <= '0;
      window_data    <= '0;
      fb_config      <= '0;
      ramdac_ctrl    <= '0;
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mem_size_sel <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        window_address <= window_address_next;
        window_data    <= window_data_next;
        fb_config      <= fb_config_next;
        ramdac_ctrl    <= ramdac_ctrl_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.req_type   <= s_tuser[0];
      in_req.reg_offset <= s_tdata[4:0];
      in_req.write_data <= s_tdata[12:5];
    end
    if (advance) begin
      out_rsp <= rsp_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_rsp.vram_write;
  assign m_tdata  = {7'h00, out_rsp.vram_data, out_rsp.vram_addr, out_rsp.read_data};

  a_vram_no_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'h00))
    else $error("video memory beat carries read data");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[64:8] == '0))
    else $error("non-commit beat carries address or data");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_req)))
    else $error("input register lost a stalled beat");

endmodule

// ===== tb/indirect_register_window_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_register_window_test
// Drives byte accesses into the indirect register window and checks every
// result beat against a cycle-free model of the window, its address and data
// assembly, the two control registers and the video memory commits. Walks
// through all memory sizes, with bursty sender traffic and receiver stalls.
// ----------------------------------------------------------------------------
module indirect_register_window_test;
  import irw_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 105;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_data = '0;

  indirect_register_window u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  irw_req_t    req_backlog[$];
  irw_rsp_t    rsp_expect[$];
  irw_req_t    req_on_bus;
  int          error_count = 0;

  logic [1:0]  size_sel = 2'd0;
  logic [31:0] win_addr = '0;
  logic [31:0] win_data = '0;
  logic [31:0] fb_cfg = '0;
  logic [31:0] dac_ctrl = '0;

  function automatic logic [31:0] vram_mask();
    logic [31:0] m;
    m = (32'h0040_0000 << size_sel) - 32'd1;
    return m & ((32'd1 << VRAM_ADDR_BITS) - 32'd1);
  endfunction

  function automatic logic [7:0] space_byte(logic [31:0] a);
    logic [23:0] ra;
    ra = a[23:0];
    case (ra)
      BUS_ID0_ADDR:  return BUS_ID0_BYTE;
      BUS_ID1_ADDR:  return BUS_ID1_BYTE;
      BUS_ID2_ADDR:  return BUS_ID2_BYTE;
      SIZE_REG_ADDR: return SIZE_BASE_BYTE | {6'd0, size_sel + 2'd1};
      default: ;
    endcase
    if (ra >= FB_CONFIG_ADDR && ra <= FB_CONFIG_ADDR + 24'd3)
      return fb_cfg[8*ra[1:0] +: 8];
    if (ra >= RAMDAC_CTRL_ADDR && ra <= RAMDAC_CTRL_ADDR + 24'd3)
      return dac_ctrl[8*ra[1:0] +: 8];
    return 8'h00;
  endfunction

  function automatic irw_rsp_t window_step(irw_req_t r);
    irw_rsp_t    rsp;
    logic [1:0]  lane;
    logic [31:0] vaddr;
    rsp = '0;
    lane = r.reg_offset[1:0];
    if (r.req_type == REQ_READ) begin
      if (r.reg_offset < 5'd4)
        rsp.read_data = ID_BYTES[lane];
      else if (r.reg_offset >= 5'd8 && r.reg_offset <= 5'd11)
        rsp.read_data = space_byte(win_addr + {30'd0, lane});
    end else begin
      if (r.reg_offset >= 5'd4 && r.reg_offset <= 5'd7) begin
        win_addr[8*lane +: 8] = r.write_data;
      end else if (r.reg_offset >= 5'd8 && r.reg_offset <= 5'd23) begin
        win_data[8*lane +: 8] = r.write_data;
        if (lane == 2'd3) begin
          if (win_addr < REG_SPACE_LIMIT) begin
            if (win_addr[23:0] == FB_CONFIG_ADDR)
              fb_cfg = win_data;
            else if (win_addr[23:0] == RAMDAC_CTRL_ADDR)
              dac_ctrl = win_data;
          end else begin
            vaddr = (win_addr - REG_SPACE_LIMIT) & vram_mask();
            rsp.vram_write = 1'b1;
            rsp.vram_addr = vaddr[VRAM_ADDR_BITS-1:0];
            rsp.vram_data = win_data;
          end
        end
      end
      if (r.reg_offset[4])
        win_addr = win_addr + 32'd4;
    end
    return rsp;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // sender: bursts of random length, random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid)
        rsp_expect.push_back(window_step(req_on_bus));
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        req_on_bus = req_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {3'd0, req_on_bus.write_data, req_on_bus.reg_offset};
        s_tuser <= req_on_bus.req_type;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left = $urandom_range(1, 7);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switching mode after a random run
  int rdy_mode = 0;
  int rdy_left = 0;
  int rdy_tick = 0;

  always @(posedge clk) begin
    if (rdy_left <= 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(16, 96);
    end
    rdy_left--;
    rdy_tick++;
    case (rdy_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= (rdy_tick % 3) != 0;
      2:       m_tready <= ($urandom_range(0, 99) < 30);
      default: m_tready <= ($urandom_range(0, 99) < 75);
    endcase
  end

  always @(posedge clk) begin
    irw_rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (rsp_expect.size() == 0) begin
        report("unexpected beat", m_tdata[31:0], 32'd0);
      end else begin
        want = rsp_expect.pop_front();
        if (m_tdata[7:0] !== want.read_data)
          report("read_data", 32'(m_tdata[7:0]), 32'(want.read_data));
        if (m_tuser[0] !== want.vram_write)
          report("vram_write", 32'(m_tuser[0]), 32'(want.vram_write));
        if (m_tdata[32:8] !== want.vram_addr)
          report("vram_addr", 32'(m_tdata[32:8]), 32'(want.vram_addr));
        if (m_tdata[64:33] !== want.vram_data)
          report("vram_data", m_tdata[64:33], want.vram_data);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic put_req(logic kind, int off, int data);
    irw_req_t r;
    r.req_type = kind;
    r.reg_offset = off[4:0];
    r.write_data = data[7:0];
    req_backlog.push_back(r);
  endtask

  task automatic set_addr(logic [31:0] a);
    for (int i = 0; i < 4; i++)
      put_req(REQ_WRITE, 4 + i, int'(a[8*i +: 8]));
  endtask

  task automatic commit_word(logic [31:0] w, int base);
    for (int i = 0; i < 4; i++)
      put_req(REQ_WRITE, base + i, int'(w[8*i +: 8]));
  endtask

  task automatic read_lanes();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      put_req(REQ_READ, 8 + $urandom_range(0, 3), $urandom);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return {8'h00, FB_CONFIG_ADDR};
      1: return {8'h00, RAMDAC_CTRL_ADDR};
      2: return {8'h00, SIZE_REG_ADDR};
      3: case ($urandom_range(0, 3))
           0: return 32'h0000_0000;
           1: return 32'h0010_01fe;
           2: return 32'h0068_05fd;
           default: return 32'h00ff_fffc;
         endcase
      4: return {8'h00, 24'($urandom)};
      5: return {8'($urandom_range(1, 255)),
                 ($urandom_range(0, 1) != 0) ? FB_CONFIG_ADDR : RAMDAC_CTRL_ADDR};
      6: return $urandom;
      default: return ($urandom_range(0, 1) != 0) ? 32'hffff_fffc : REG_SPACE_LIMIT;
    endcase
  endfunction

  task automatic add_sequence();
    logic [31:0] a;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        set_addr(pick_addr());
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 1) != 0)
            commit_word($urandom, 8 + 4 * $urandom_range(0, 3));
          else
            read_lanes();
        end
      end
      4: put_req(REQ_WRITE, 4 + $urandom_range(0, 3), $urandom);
      5: put_req(REQ_WRITE, 8 + $urandom_range(0, 15), $urandom);
      6: put_req(REQ_READ, $urandom_range(0, 31), $urandom);
      7: read_lanes();
      8: put_req(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom);
      default: begin
        a = ($urandom_range(0, 1) != 0) ? {8'h00, FB_CONFIG_ADDR}
                                        : {8'h00, RAMDAC_CTRL_ADDR};
        set_addr(a);
        commit_word($urandom, 8);
        read_lanes();
      end
    endcase
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || s_tvalid || rsp_expect.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mem_size(logic [1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    size_sel = v;
    cfg_valid <= 1'b0;
  endtask

  logic [1:0] size_plan [6] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ID bytes, fb_config round trip, an auto-incrementing commit whose address
    // wraps into register space, advance-only and store-nothing writes
    for (int i = 0; i < 4; i++)
      put_req(REQ_READ, i, 'hff);
    set_addr({8'h00, FB_CONFIG_ADDR});
    commit_word(32'ha5c3_0ff0, 8);
    put_req(REQ_READ, 8, 'h00);
    put_req(REQ_READ, 11, 'h00);
    set_addr(32'hffff_fffc);
    commit_word(32'hffff_ffff, 20);
    put_req(REQ_READ, 8, 'h00);
    put_req(REQ_WRITE, 31, 'h00);
    put_req(REQ_WRITE, 0, 'hff);
    drain();

    foreach (size_plan[p]) begin
      set_mem_size(size_plan[p]);
      target = req_backlog.size() + PHASE_ITEMS / 2;
      while (req_backlog.size() < target)
        add_sequence();
      // hold off until every result is back
      drain();
      target = PHASE_ITEMS - PHASE_ITEMS / 2;
      while (req_backlog.size() < target)
        add_sequence();
      drain();
    end

    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== indirect_register_window.f =====
design/irw_pkg.sv
design/indirect_register_window.sv
tb/indirect_register_window_test.sv
